[rtl/core/s4acl_pkg.sv]
// Shared types, codes and helpers for the SOCKS4 request rule check.
`default_nettype none

package s4acl_pkg;

    localparam int RULE_COUNT_DEF = 16;

    localparam logic       CMD_STORE     = 1'b0;
    localparam logic       CMD_CHECK     = 1'b1;
    localparam logic       KIND_CONNECT  = 1'b0;
    localparam logic       KIND_BIND     = 1'b1;
    localparam logic       RES_ACK       = 1'b0;
    localparam logic       RES_VERDICT   = 1'b1;
    localparam logic [7:0] SOCKS_VERSION = 8'd4;
    localparam logic [7:0] REQ_CONNECT   = 8'd1;
    localparam logic [7:0] REQ_BIND      = 8'd2;
    localparam logic [7:0] CODE_NONE     = 8'd0;
    localparam logic [7:0] CODE_GRANTED  = 8'd90;
    localparam logic [7:0] CODE_REJECTED = 8'd91;

    localparam logic [1:0] VERDICT_ACCEPTED = 2'd0;
    localparam logic [1:0] VERDICT_REJECTED = 2'd1;
    localparam logic [1:0] VERDICT_VERSION  = 2'd2;
    localparam logic [1:0] VERDICT_LOOKUP   = 2'd3;

    typedef struct packed {
        logic        command;
        logic [3:0]  rule_slot;
        logic        rule_enable;
        logic        rule_kind;
        logic [31:0] rule_address;
        logic [3:0]  rule_wildcards;
        logic [7:0]  req_version;
        logic [7:0]  req_code;
        logic [31:0] req_address;
        logic [15:0] req_port;
    } t_in_word;

    typedef struct packed {
        logic        result_kind;
        logic        send_reply;
        logic [7:0]  reply_code;
        logic [1:0]  verdict;
        logic [31:0] out_address;
        logic [15:0] out_port;
    } t_out_word;

    typedef struct packed {
        logic        kind;
        logic [31:0] address;
        logic [3:0]  wildcards;
    } t_rule;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_EMIT
    } t_state;

    function automatic logic [31:0] care_mask(input logic [3:0] wild);
        care_mask = {{8{~wild[3]}}, {8{~wild[2]}}, {8{~wild[1]}}, {8{~wild[0]}}};
    endfunction

endpackage

`default_nettype wire

[rtl/core/socks4_request_acl_check_top.sv]
// Top level: SOCKS4 request check against a wildcard address rule table.
// Flow: a rule store word goes from acceptance through S_EMIT to the output
//   register; a request that scans the table passes S_SCAN, S_DRAIN and S_EMIT.
// One word at a time: input is taken only in S_IDLE, S_EMIT waits for a free
//   output register, and the single memory read port scans one rule a cycle.
// Reset: synchronous, active low; clears all rule valid bits and the output valid.
`default_nettype none

module socks4_request_acl_check_top
    import s4acl_pkg::*;
#(
    parameter int RULE_COUNT = RULE_COUNT_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_word  i_in_word,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_word      o_out_word
);

    localparam int IDX_W = (RULE_COUNT > 1) ? $clog2(RULE_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RULE_COUNT - 1);

    t_rule                  r_mem [RULE_COUNT];
    logic [RULE_COUNT-1:0]  r_valid;
    t_state                 r_state, n_state;
    logic [IDX_W-1:0]       r_idx;
    logic [IDX_W-1:0]       r_rd_idx;
    logic                   r_rd_act;
    t_rule                  r_rd_data;
    logic                   r_hit;
    logic                   r_scan;
    logic [31:0]            r_req_addr;
    logic [15:0]            r_req_port;
    logic                   r_req_kind;
    t_out_word              r_res;
    t_out_word              r_out;
    logic                   r_out_valid;

    logic                   w_in_acc;
    logic                   w_slot_ok;
    logic [IDX_W-1:0]       w_wr_idx;
    logic                   w_need_scan;
    t_out_word              w_res_init;
    t_out_word              n_res;
    logic                   w_emit;
    logic                   w_match;

    assign w_in_acc  = i_in_valid && o_in_ready;
    assign w_slot_ok = {3'b000, i_in_word.rule_slot} < 7'(RULE_COUNT);
    assign w_wr_idx  = IDX_W'(i_in_word.rule_slot);

    always_comb begin
        w_res_init             = '0;
        w_need_scan            = 1'b0;
        w_res_init.result_kind = RES_ACK;
        if (i_in_word.command == CMD_CHECK) begin
            w_res_init.result_kind = RES_VERDICT;
            if (i_in_word.req_version != SOCKS_VERSION) begin
                w_res_init.verdict = VERDICT_VERSION;
            end else if (i_in_word.req_address[31:8] == 24'd0 &&
                         i_in_word.req_address[7:0] != 8'd0) begin
                w_res_init.verdict     = VERDICT_LOOKUP;
                w_res_init.out_address = i_in_word.req_address;
                w_res_init.out_port    = i_in_word.req_port;
            end else begin
                w_res_init.send_reply = 1'b1;
                w_res_init.reply_code = CODE_REJECTED;
                w_res_init.verdict    = VERDICT_REJECTED;
                w_need_scan = i_in_word.req_code inside {REQ_CONNECT, REQ_BIND};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_in_word.command == CMD_STORE && w_slot_ok) begin
            r_mem[w_wr_idx] <= '{kind:      i_in_word.rule_kind,
                                 address:   i_in_word.rule_address,
                                 wildcards: i_in_word.rule_wildcards};
        end
        r_rd_data <= r_mem[r_idx];
        r_rd_idx  <= r_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_in_acc && i_in_word.command == CMD_STORE && w_slot_ok) begin
            r_valid[w_wr_idx] <= i_in_word.rule_enable;
        end
    end

    assign w_match = r_valid[r_rd_idx] && (r_rd_data.kind == r_req_kind) &&
                     (((r_rd_data.address ^ r_req_addr) &
                       care_mask(r_rd_data.wildcards)) == 32'd0);

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_req_addr <= i_in_word.req_address;
            r_req_port <= i_in_word.req_port;
            r_req_kind <= (i_in_word.req_code == REQ_BIND) ? KIND_BIND : KIND_CONNECT;
            r_res      <= w_res_init;
            r_scan     <= (i_in_word.command == CMD_CHECK) && w_need_scan;
            r_hit      <= 1'b0;
            r_idx      <= '0;
        end else begin
            if (r_state == S_SCAN && r_idx != LAST_IDX) begin
                r_idx <= r_idx + 1'b1;
            end
            if (r_rd_act && w_match) begin
                r_hit <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rd_act <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_act <= (r_state == S_SCAN);
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        w_emit     = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = i_rst_n;
                if (w_in_acc) begin
                    n_state = (i_in_word.command == CMD_CHECK && w_need_scan) ?
                              S_SCAN : S_EMIT;
                end
            end
            S_SCAN: begin
                if (r_idx == LAST_IDX) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    w_emit  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_res = r_res;
        if (r_scan && r_hit) begin
            n_res.reply_code  = CODE_GRANTED;
            n_res.verdict     = VERDICT_ACCEPTED;
            n_res.out_address = r_req_addr;
            n_res.out_port    = r_req_port;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out <= n_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    a_read_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_act |-> (r_state == S_SCAN || r_state == S_DRAIN))
        else $error("read data pending outside the table scan");

    a_store_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_in_word.command == CMD_STORE && w_slot_ok) |=>
        (r_valid[$past(w_wr_idx)] == $past(i_in_word.rule_enable)))
        else $error("rule valid bit not updated by store");

    a_emit_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && !r_out_valid) |=> (r_out_valid && r_state == S_IDLE))
        else $error("result not loaded into free output register");

    a_ack_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.result_kind == RES_ACK) |->
        (!o_out_word.send_reply && o_out_word.reply_code == CODE_NONE &&
         o_out_word.out_address == 32'd0))
        else $error("store acknowledgment carries request fields");

    a_grant_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.result_kind == RES_VERDICT &&
         o_out_word.verdict == VERDICT_ACCEPTED) |->
        (o_out_word.send_reply && o_out_word.reply_code == CODE_GRANTED))
        else $error("granted verdict without granted reply code");

endmodule

`default_nettype wire
